FILE: rtl/coulomb_friction_row_unit_macros.svh
// Assertion macros for the Coulomb friction row unit.
// Taken in by the top level; relies on aclk and aresetn in the including scope.
`ifndef COULOMB_FRICTION_ROW_UNIT_MACROS_SVH
`define COULOMB_FRICTION_ROW_UNIT_MACROS_SVH

// Implication checked on the same edge, switched off while reset is held.
`define CFR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("coulomb_friction_row_unit check failed");

// Implication checked on the following edge, active during reset as well.
`define CFR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("coulomb_friction_row_unit check failed");

`endif

FILE: rtl/cfr_pkg.sv
// Shared widths, codes and stage records of the Coulomb friction row unit.
// No dependencies; every RTL module refers to it by scoped names.
`default_nettype none
package cfr_pkg;

    localparam int MU_W    = 25;
    localparam int N_W     = 18;
    localparam int V_W     = 32;
    localparam int ROW_W   = 32;
    localparam int BOUND_W = 31;
    localparam int MAG_W   = 30;
    localparam int SQ_W    = 62;
    localparam int ROOT_W  = 31;
    localparam int RECIP_W = 33;
    localparam int REM0_EXP = 28;

    localparam logic [1:0] MODE_A = 2'd1;
    localparam logic [1:0] MODE_B = 2'd2;

    typedef struct packed {
        logic                   active;
        logic                   body_a;
        logic                   tzero;
        logic [2:0]             neg;
        logic [2:0][MAG_W-1:0]  mag;
        logic [BOUND_W-1:0]     bound;
        logic                   sat;
    } cfr_side_t;

    typedef struct packed {
        cfr_side_t          side;
        logic [SQ_W-1:0]    sumsq;
    } cfr_sq_t;

    typedef struct packed {
        cfr_side_t          side;
        logic [ROOT_W-1:0]  root;
    } cfr_root_t;

    typedef struct packed {
        cfr_side_t          side;
        logic [RECIP_W-1:0] recip;
    } cfr_recip_t;

endpackage
`default_nettype wire

FILE: rtl/cfr_front.sv
// Front pipeline: dot products, tangent projection, bound, normalising shift, squares.
// Eight register stages; uses cfr_pkg.
`default_nettype none
module cfr_front (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [1:0]                   mode_i,
    input  wire logic signed [17:0]           nrm_i [3],
    input  wire logic signed [31:0]           vel_i [3],
    input  wire logic signed [31:0]           frc_i [3],
    input  wire logic [cfr_pkg::MU_W-1:0]     mu_i,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output cfr_pkg::cfr_sq_t                  out_data
);

    localparam int NST = 8;

    logic vld_reg [NST];
    logic rdy [NST+1];

    logic signed [49:0] pv1_reg [3], pf1_reg [3], pv1_next [3], pf1_next [3];
    logic signed [17:0] n1_reg [3], n2_reg [3];
    logic signed [31:0] v1_reg [3], v2_reg [3], v3_reg [3];
    logic [1:0]         mode1_reg, mode2_reg, mode3_reg, mode4_reg, mode5_reg;
    logic signed [50:0] dv2_reg, df2_reg, dv2_next, df2_next;
    logic signed [34:0] vn3;
    logic signed [50:0] fd3;
    logic signed [52:0] pn3_reg [3], pn3_next [3];
    logic [33:0]        fn3_reg, fn3_next;
    logic signed [37:0] vt4_reg [3], vt4_next [3];
    logic [58:0]        bp4_reg, bp4_next;
    logic [36:0]        mag5_reg [3], mag5_next [3];
    logic [37:0]        negv5 [3];
    logic [36:0]        orv5;
    logic [2:0]         neg5_reg, neg5_next;
    logic [5:0]         lead5_reg, lead5_next;
    logic               nz5_reg, nz5_next;
    logic [30:0]        bound5_reg, bound5_next;
    logic               sat5_reg, sat5_next;
    logic [65:0]        sh6 [3];
    cfr_pkg::cfr_side_t side6_reg, side6_next, side7_reg;
    logic [59:0]        sq7_reg [3], sq7_next [3];
    cfr_pkg::cfr_sq_t   out_reg, out_next;

    assign rdy[NST] = out_ready;
    for (genvar k = 0; k < NST; k++) begin : g_rdy
        assign rdy[k] = !vld_reg[k] || rdy[k+1];
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (rdy[k]) begin
                vld_reg[k] <= (k == 0) ? in_valid : vld_reg[(k == 0) ? 0 : k-1];
            end
        end
    end
    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[NST-1];
    assign out_data  = out_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pv1_next[i] = nrm_i[i] * vel_i[i];
            pf1_next[i] = nrm_i[i] * frc_i[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            pv1_reg   <= pv1_next;
            pf1_reg   <= pf1_next;
            n1_reg    <= nrm_i;
            v1_reg    <= vel_i;
            mode1_reg <= mode_i;
        end
    end

    always_comb begin
        dv2_next = 51'(pv1_reg[0]) + 51'(pv1_reg[1]) + 51'(pv1_reg[2]);
        df2_next = 51'(pf1_reg[0]) + 51'(pf1_reg[1]) + 51'(pf1_reg[2]);
    end

    always_ff @(posedge aclk) begin
        if (rdy[1]) begin
            dv2_reg   <= dv2_next;
            df2_reg   <= df2_next;
            n2_reg    <= n1_reg;
            v2_reg    <= v1_reg;
            mode2_reg <= mode1_reg;
        end
    end

    always_comb begin
        vn3 = $signed(dv2_reg[50:16]);
        for (int i = 0; i < 3; i++) begin
            pn3_next[i] = vn3 * n2_reg[i];
        end
        fd3      = (mode2_reg == cfr_pkg::MODE_A) ? -df2_reg : df2_reg;
        fn3_next = fd3[50] ? 34'd0 : fd3[49:16];
    end

    always_ff @(posedge aclk) begin
        if (rdy[2]) begin
            pn3_reg   <= pn3_next;
            fn3_reg   <= fn3_next;
            v3_reg    <= v2_reg;
            mode3_reg <= mode2_reg;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            vt4_next[i] = 38'(v3_reg[i]) - 38'($signed(pn3_reg[i][52:16]));
        end
        bp4_next = 59'(mu_i) * 59'(fn3_reg);
    end

    always_ff @(posedge aclk) begin
        if (rdy[3]) begin
            vt4_reg   <= vt4_next;
            bp4_reg   <= bp4_next;
            mode4_reg <= mode3_reg;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            negv5[i]     = -vt4_reg[i];
            neg5_next[i] = vt4_reg[i][37];
            mag5_next[i] = vt4_reg[i][37] ? negv5[i][36:0] : vt4_reg[i][36:0];
        end
        orv5       = mag5_next[0] | mag5_next[1] | mag5_next[2];
        nz5_next   = |orv5;
        lead5_next = 6'd0;
        for (int j = 0; j < 37; j++) begin
            if (orv5[j]) begin
                lead5_next = 6'(j);
            end
        end
        sat5_next   = |bp4_reg[58:47];
        bound5_next = sat5_next ? {31{1'b1}} : bp4_reg[46:16];
    end

    always_ff @(posedge aclk) begin
        if (rdy[4]) begin
            mag5_reg   <= mag5_next;
            neg5_reg   <= neg5_next;
            lead5_reg  <= lead5_next;
            nz5_reg    <= nz5_next;
            bound5_reg <= bound5_next;
            sat5_reg   <= sat5_next;
            mode5_reg  <= mode4_reg;
        end
    end

    always_comb begin
        side6_next.active = (mode5_reg == cfr_pkg::MODE_A) || (mode5_reg == cfr_pkg::MODE_B);
        side6_next.body_a = (mode5_reg == cfr_pkg::MODE_A);
        side6_next.tzero  = !nz5_reg;
        side6_next.neg    = neg5_reg;
        for (int i = 0; i < 3; i++) begin
            sh6[i]            = ({29'd0, mag5_reg[i]} << 29) >> lead5_reg;
            side6_next.mag[i] = sh6[i][29:0];
        end
        side6_next.bound = bound5_reg;
        side6_next.sat   = sat5_reg;
    end

    always_ff @(posedge aclk) begin
        if (rdy[5]) begin
            side6_reg <= side6_next;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sq7_next[i] = 60'(side6_reg.mag[i]) * 60'(side6_reg.mag[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[6]) begin
            sq7_reg   <= sq7_next;
            side7_reg <= side6_reg;
        end
    end

    always_comb begin
        out_next.side  = side7_reg;
        out_next.sumsq = 62'(sq7_reg[0]) + 62'(sq7_reg[1]) + 62'(sq7_reg[2]);
    end

    always_ff @(posedge aclk) begin
        if (rdy[7]) begin
            out_reg <= out_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/cfr_isqrt.sv
// Square root pipeline: one result bit per register stage, remainder carried along.
// Uses cfr_pkg.
`default_nettype none
module cfr_isqrt (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire cfr_pkg::cfr_sq_t   in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output cfr_pkg::cfr_root_t      out_data
);

    localparam int NST = cfr_pkg::ROOT_W;

    typedef struct packed {
        cfr_pkg::cfr_side_t             side;
        logic [cfr_pkg::SQ_W-1:0]       rem;
        logic [cfr_pkg::ROOT_W-1:0]     root;
    } stage_t;

    logic   vld_reg [NST];
    logic   rdy [NST+1];
    stage_t stg_reg [NST];
    stage_t stg_in [NST];
    logic   vin [NST];

    assign rdy[NST] = out_ready;
    assign in_ready = rdy[0];

    for (genvar j = 0; j < NST; j++) begin : g_stage
        localparam int B = NST - 1 - j;
        logic [cfr_pkg::SQ_W:0] trial;
        stage_t                 stg_next;

        if (j == 0) begin : g_first
            assign vin[j]         = in_valid;
            assign stg_in[j].side = in_data.side;
            assign stg_in[j].rem  = in_data.sumsq;
            assign stg_in[j].root = '0;
        end else begin : g_rest
            assign vin[j]    = vld_reg[j-1];
            assign stg_in[j] = stg_reg[j-1];
        end

        assign rdy[j] = !vld_reg[j] || rdy[j+1];

        always_comb begin
            trial    = ((cfr_pkg::SQ_W+1)'(stg_in[j].root) << (B + 1))
                     + ((cfr_pkg::SQ_W+1)'(1) << (2 * B));
            stg_next = stg_in[j];
            if ((cfr_pkg::SQ_W+1)'(stg_in[j].rem) >= trial) begin
                stg_next.rem  = stg_in[j].rem - trial[cfr_pkg::SQ_W-1:0];
                stg_next.root = stg_in[j].root | (cfr_pkg::ROOT_W'(1) << B);
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[j] <= 1'b0;
            end else if (rdy[j]) begin
                vld_reg[j] <= vin[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy[j]) begin
                stg_reg[j] <= stg_next;
            end
        end
    end

    assign out_valid     = vld_reg[NST-1];
    assign out_data.side = stg_reg[NST-1].side;
    assign out_data.root = stg_reg[NST-1].root;

endmodule
`default_nettype wire

FILE: rtl/cfr_recip.sv
// Reciprocal pipeline: restoring division of a fixed power of two, one quotient bit a stage.
// Uses cfr_pkg.
`default_nettype none
module cfr_recip (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire cfr_pkg::cfr_root_t in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output cfr_pkg::cfr_recip_t     out_data
);

    localparam int NST = cfr_pkg::RECIP_W;

    typedef struct packed {
        cfr_pkg::cfr_side_t             side;
        logic [cfr_pkg::ROOT_W-1:0]     dvs;
        logic [cfr_pkg::ROOT_W:0]       rem;
        logic [cfr_pkg::RECIP_W-1:0]    quo;
    } stage_t;

    logic   vld_reg [NST];
    logic   rdy [NST+1];
    stage_t stg_reg [NST];
    stage_t stg_in [NST];
    logic   vin [NST];

    assign rdy[NST] = out_ready;
    assign in_ready = rdy[0];

    for (genvar j = 0; j < NST; j++) begin : g_stage
        localparam int Q = NST - 1 - j;
        logic [cfr_pkg::ROOT_W:0] rem2;
        stage_t                   stg_next;

        if (j == 0) begin : g_first
            assign vin[j]         = in_valid;
            assign stg_in[j].side = in_data.side;
            assign stg_in[j].dvs  = in_data.root;
            assign stg_in[j].rem  = (cfr_pkg::ROOT_W+1)'(1) << cfr_pkg::REM0_EXP;
            assign stg_in[j].quo  = '0;
        end else begin : g_rest
            assign vin[j]    = vld_reg[j-1];
            assign stg_in[j] = stg_reg[j-1];
        end

        assign rdy[j] = !vld_reg[j] || rdy[j+1];

        always_comb begin
            rem2     = {stg_in[j].rem[cfr_pkg::ROOT_W-1:0], 1'b0};
            stg_next = stg_in[j];
            stg_next.rem = rem2;
            if (rem2 >= (cfr_pkg::ROOT_W+1)'(stg_in[j].dvs)) begin
                stg_next.rem = rem2 - (cfr_pkg::ROOT_W+1)'(stg_in[j].dvs);
                stg_next.quo = stg_in[j].quo | (cfr_pkg::RECIP_W'(1) << Q);
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[j] <= 1'b0;
            end else if (rdy[j]) begin
                vld_reg[j] <= vin[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy[j]) begin
                stg_reg[j] <= stg_next;
            end
        end
    end

    assign out_valid      = vld_reg[NST-1];
    assign out_data.side  = stg_reg[NST-1].side;
    assign out_data.recip = stg_reg[NST-1].quo;

endmodule
`default_nettype wire

FILE: rtl/cfr_back.sv
// Back end: scales the normalised magnitudes by the reciprocal, rounds, clamps, signs, masks.
// Two register stages, the second being the output register; uses cfr_pkg.
`default_nettype none
module cfr_back (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire cfr_pkg::cfr_recip_t         in_data,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [cfr_pkg::ROW_W-1:0]        row_o [3],
    output logic [cfr_pkg::BOUND_W-1:0]      bound_o,
    output logic                             tzero_o,
    output logic                             sat_o
);

    logic               vld1_reg, vld2_reg, rdy1, rdy2;
    logic [62:0]        prod1_reg [3], prod1_next [3];
    cfr_pkg::cfr_side_t side1_reg;
    logic [62:0]        rnd2 [3];
    logic [31:0]        t2 [3];
    logic [cfr_pkg::ROW_W-1:0]   row2_reg [3], row2_next [3];
    logic [cfr_pkg::BOUND_W-1:0] bound2_reg, bound2_next;
    logic               tzero2_reg, tzero2_next, sat2_reg, sat2_next;

    assign rdy2     = !vld2_reg || out_ready;
    assign rdy1     = !vld1_reg || rdy2;
    assign in_ready = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                vld1_reg <= in_valid;
            end
            if (rdy2) begin
                vld2_reg <= vld1_reg;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            prod1_next[i] = 63'(in_data.side.mag[i]) * 63'(in_data.recip);
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            prod1_reg <= prod1_next;
            side1_reg <= in_data.side;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            rnd2[i] = prod1_reg[i] + (63'(1) << 30);
            t2[i]   = rnd2[i][62:31];
            if (t2[i] > (32'(1) << 30)) begin
                t2[i] = 32'(1) << 30;
            end
            if (!side1_reg.active || side1_reg.tzero) begin
                row2_next[i] = '0;
            end else if (side1_reg.neg[i] ^ side1_reg.body_a) begin
                row2_next[i] = -t2[i];
            end else begin
                row2_next[i] = t2[i];
            end
        end
        bound2_next = side1_reg.active ? side1_reg.bound : '0;
        tzero2_next = side1_reg.active && side1_reg.tzero;
        sat2_next   = side1_reg.active && side1_reg.sat;
    end

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            row2_reg   <= row2_next;
            bound2_reg <= bound2_next;
            tzero2_reg <= tzero2_next;
            sat2_reg   <= sat2_next;
        end
    end

    assign out_valid = vld2_reg;
    assign row_o     = row2_reg;
    assign bound_o   = bound2_reg;
    assign tzero_o   = tzero2_reg;
    assign sat_o     = sat2_reg;

endmodule
`default_nettype wire

FILE: rtl/coulomb_friction_row_unit.sv
// Coulomb friction row unit: tangent row and friction bound for one body of a contact.
// An accepted input beat passes 8 front stages, 31 square root stages, 33 reciprocal
// stages and 2 back stages, one bit or step each, on its way to its result beat.
// Throughput is one beat per cycle; the pipeline only stalls where the result side does.
// Synchronous active-low reset empties every stage and clears the friction coefficient.
`default_nettype none
`include "coulomb_friction_row_unit_macros.svh"
module coulomb_friction_row_unit (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cfg_we,
    input  wire logic [24:0]   cfg_wdata,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    // normal_x, normal_y, normal_z, velocity_x, velocity_y, velocity_z,
    // force_x, force_y, force_z, then two zero bits
    input  wire logic [247:0]  s_tdata,
    // mode
    input  wire logic [1:0]    s_tuser,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // row_x, row_y, row_z, friction_bound, then one zero bit
    output logic [127:0]       m_tdata,
    // tangent_zero, bound_saturated
    output logic [1:0]         m_tuser
);

    logic [cfr_pkg::MU_W-1:0]    mu_reg;
    logic signed [17:0]          nrm [3];
    logic signed [31:0]          vel [3];
    logic signed [31:0]          frc [3];
    logic                        f_valid, f_ready, q_valid, q_ready, r_valid, r_ready;
    cfr_pkg::cfr_sq_t            f_data;
    cfr_pkg::cfr_root_t          q_data;
    cfr_pkg::cfr_recip_t         r_data;
    logic [cfr_pkg::ROW_W-1:0]   row [3];
    logic [cfr_pkg::BOUND_W-1:0] bound;
    logic                        tzero, sat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mu_reg <= '0;
        end else if (cfg_we) begin
            mu_reg <= cfg_wdata;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            nrm[i] = $signed(s_tdata[18*i +: 18]);
            vel[i] = $signed(s_tdata[54 + 32*i +: 32]);
            frc[i] = $signed(s_tdata[150 + 32*i +: 32]);
        end
    end

    cfr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .mode_i    (s_tuser),
        .nrm_i     (nrm),
        .vel_i     (vel),
        .frc_i     (frc),
        .mu_i      (mu_reg),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_data  (f_data)
    );

    cfr_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_data),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    cfr_recip u_recip (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_data   (q_data),
        .out_valid (r_valid),
        .out_ready (r_ready),
        .out_data  (r_data)
    );

    cfr_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (r_valid),
        .in_ready  (r_ready),
        .in_data   (r_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .row_o     (row),
        .bound_o   (bound),
        .tzero_o   (tzero),
        .sat_o     (sat)
    );

    assign m_tdata = {1'b0, bound, row[2], row[1], row[0]};
    assign m_tuser = {sat, tzero};

    `CFR_ASSERT_NOW(a_tzero_rows, m_tvalid && m_tuser[0], m_tdata[95:0] == 96'd0)
    `CFR_ASSERT_NOW(a_sat_bound, m_tvalid && m_tuser[1], m_tdata[126:96] == {31{1'b1}})
    `CFR_ASSERT_NEXT(a_reset_empty, !aresetn, !m_tvalid && mu_reg == '0)
    `CFR_ASSERT_NEXT(a_cfg_write, aresetn && cfg_we, mu_reg == $past(cfg_wdata))

endmodule
`default_nettype wire
